FILE: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by the controller, the datapath and the top level; depends on nothing.
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;

	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic                    operation;
		logic [KEY_W-1:0]        lookup_key;
		logic signed [VAL_W-1:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage

FILE: rtl/lkv_ctrl.sv
// Controller state machine for the LRU key-value cache.
// Sequences capture and commit of each access and owns the output valid flag; uses lkv_pkg.
module lkv_ctrl
	import lkv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		in_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_UPDATE: begin
				cmd.commit = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/lkv_dp.sv
// Datapath of the LRU key-value cache: recency-ordered slot stack, associative
// match, occupancy and capacity registers, and the result register. Uses lkv_pkg.
module lkv_dp
	import lkv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  in_item_t         in_item,
	input  logic             cfg_write_en,
	input  logic [CAP_W-1:0] cfg_write_data,
	output out_item_t        out_item
);

	// Slot 0 holds the most recent entry; slot occupancy-1 the least recent.
	logic [KEY_W-1:0] keys_q [ENTRIES];
	logic [VAL_W-1:0] vals_q [ENTRIES];
	logic [OCC_W-1:0] occ_q;
	logic [CAP_W-1:0] cap_q;
	out_item_t        out_q;

	logic             op_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] wval_s1;
	logic             hit_s1;
	logic [IDX_W-1:0] found_s1;

	logic [ENTRIES-1:0] match;
	logic [IDX_W-1:0]   found;
	logic [VAL_W-1:0]   hit_value;
	logic [VAL_W-1:0]   new_value;
	logic [CMP_W-1:0]   cap_wide;
	logic [CMP_W-1:0]   cap_eff;
	logic [CMP_W-1:0]   occ_wide;
	logic [CMP_W-1:0]   occ_adj;
	logic [IDX_W-1:0]   last;
	logic               do_push;
	logic               insert;

	// Match the incoming key against every occupied slot in the accept cycle.
	always_comb begin
		found = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			match[j] = (OCC_W'(j) < occ_q) && (keys_q[j] == in_item.lookup_key);
		end
		for (int j = ENTRIES - 1; j >= 0; j--) begin
			if (match[j]) found = IDX_W'(j);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1    <= in_item.operation;
			key_s1   <= in_item.lookup_key;
			wval_s1  <= in_item.write_value;
			hit_s1   <= |match;
			found_s1 <= found;
		end
	end

	// A capacity of zero behaves as one; anything above the slot count saturates.
	always_comb begin
		cap_wide = CMP_W'(cap_q);
		occ_wide = CMP_W'(occ_q);
		if (cap_wide == '0) cap_eff = CMP_W'(1);
		else if (cap_wide > CMP_W'(ENTRIES)) cap_eff = CMP_W'(ENTRIES);
		else cap_eff = cap_wide;
		occ_adj = (occ_wide >= cap_eff) ? cap_eff - CMP_W'(1) : occ_wide;
	end

	assign hit_value = vals_q[found_s1];
	assign new_value = (op_s1 == OP_PUT) ? wval_s1 : hit_value;
	assign insert    = (op_s1 == OP_PUT) && !hit_s1;
	assign do_push   = hit_s1 || (op_s1 == OP_PUT);
	assign last      = hit_s1 ? found_s1 : occ_adj[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.commit && do_push) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (j == 0) begin
					keys_q[j] <= key_s1;
					vals_q[j] <= new_value;
				end else if (IDX_W'(j) <= last) begin
					keys_q[j] <= keys_q[j-1];
					vals_q[j] <= vals_q[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cap_q <= CAP_RESET;
		end else begin
			if (cmd.commit && insert) occ_q <= OCC_W'(occ_adj + CMP_W'(1));
			if (cfg_write_en) cap_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.hit        <= hit_s1;
			out_q.read_value <= ((op_s1 == OP_GET) && hit_s1) ? hit_value : MISS_VALUE;
		end
	end

	assign out_item = out_q;

endmodule

FILE: rtl/lru_key_value_cache_core.sv
// LRU key-value cache: the key match happens in the accept cycle and the stack shift in the
// update state, whose commit registers the result beat; a new access waits until then.
// The input stalls during the update cycle; if the result beat is still held back, the
// update and the input wait until the result register frees.
// Reset empties the cache (occupancy zero) and sets capacity to 16; no clearing pass.
module lru_key_value_cache_core
	import lkv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item,
	input  logic             cfg_write_en,
	input  logic [CAP_W-1:0] cfg_write_data
);

	dp_cmd_t cmd;

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	lkv_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_item        (in_item),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.out_item       (out_item)
	);

endmodule

FILE: bench/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps
// Checker for the LRU key-value cache: watches both channels and the capacity port,
// keeps its own recency stack and compares every result beat. Depends on lkv_pkg.
module lru_key_value_cache_checker
	import lkv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_item_t         in_item,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_item_t        out_item,
	input  logic             cfg_write_en,
	input  logic [CAP_W-1:0] cfg_write_data,
	output int               fail_count,
	output int               pending
);

	// Slot 0 is the most recent entry; slots at or beyond fill are empty.
	logic [KEY_W-1:0] slot_key [ENTRIES];
	logic [VAL_W-1:0] slot_val [ENTRIES];
	int               fill = 0;
	logic [CAP_W-1:0] cap_copy = CAP_RESET;
	out_item_t        expected_q [$];
	int               mismatches = 0;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic out_item_t access_cache(input in_item_t acc);
		int               j;
		int               found;
		int               last;
		int               limit;
		logic             moved;
		logic [VAL_W-1:0] front_val;
		out_item_t        res;
		found = -1;
		last = 0;
		moved = 1'b0;
		front_val = acc.write_value;
		res.hit = 1'b0;
		res.read_value = MISS_VALUE;
		for (j = 0; j < fill && found < 0; j++)
			if (slot_key[j] == acc.lookup_key)
				found = j;
		if (found >= 0) begin
			res.hit = 1'b1;
			if (acc.operation == OP_GET) begin
				res.read_value = slot_val[found];
				front_val = slot_val[found];
			end
			last = found;
			moved = 1'b1;
		end else if (acc.operation == OP_PUT) begin
			// A zero capacity behaves as one, anything above the depth as the depth.
			limit = (cap_copy == 0) ? 1 : (cap_copy > ENTRIES) ? ENTRIES : int'(cap_copy);
			if (fill >= limit)
				fill = limit - 1;
			last = fill;
			fill++;
			moved = 1'b1;
		end
		if (moved) begin
			for (j = last; j > 0; j--) begin
				slot_key[j] = slot_key[j-1];
				slot_val[j] = slot_val[j-1];
			end
			slot_key[0] = acc.lookup_key;
			slot_val[0] = front_val;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			fill = 0;
			cap_copy = CAP_RESET;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (cfg_write_en)
				cap_copy = cfg_write_data;
			// Results of earlier beats are retired before this edge's input is predicted.
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no access outstanding");
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (out_item.hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, out_item.hit);
						mismatches++;
					end
					if (out_item.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							want.read_value, out_item.read_value);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(access_cache(in_item));
			pending <= expected_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: bench/lru_key_value_cache_core_tb.sv
`timescale 1ns / 1ps
// Top of the LRU key-value cache bench: clock, reset, access stimulus and the verdict.
// Depends on lkv_pkg, lru_key_value_cache_core and lru_key_value_cache_checker.
module lru_key_value_cache_core_tb;
	import lkv_pkg::*;

	localparam int PHASE_ITEMS = 150;
	localparam int QUIET_LIMIT = 4000;
	localparam int POOL_SIZE   = 20;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_item = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_item;
	logic             cfg_write_en = 1'b0;
	logic [CAP_W-1:0] cfg_write_data = '0;
	logic             calm = 1'b0;
	int unsigned      burst_left = 0;
	int unsigned      quiet = 0;
	int               fail_count;
	int               pending;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	// Capacity per random phase: zero, saturation and several drops below occupancy.
	logic [CAP_W-1:0] phase_caps [11] = '{5'd2, 5'd0, 5'd31, 5'd17, 5'd1, 5'd16,
		5'd3, 5'd9, 5'd16, 5'd4, 5'd12};

	lru_key_value_cache_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	lru_key_value_cache_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side runs random stalled and free bursts until the final phase.
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
		end else if (burst_left == 0) begin
			out_stall <= ($urandom_range(0, 2) == 0);
			burst_left <= $urandom_range(0, 13);
		end else begin
			burst_left <= burst_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("lru_key_value_cache_core regression: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Presents one access and holds it until the beat is taken, then maybe idles.
	task automatic access(input logic op, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] wval);
		in_valid <= 1'b1;
		in_item <= '{operation: op, lookup_key: key, write_value: wval};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14))
				@(posedge clk);
		end
	endtask

	// The capacity is only written once every outstanding access has returned.
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (3)
			@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= cap;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic run_phase(input logic [CAP_W-1:0] cap, input int items);
		int               span;
		int               pick;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] wval;
		set_capacity(cap);
		// A key set a little larger than the capacity gives both hits and evictions.
		span = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : int'(cap);
		span = span + $urandom_range(1, 4);
		if (span > POOL_SIZE)
			span = POOL_SIZE;
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (items) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				key = key_pool[$urandom_range(0, span - 1)];
			else if (pick == 7)
				key = $urandom_range(0, 1) ? '1 : '0;
			else
				key = $urandom;
			case ($urandom_range(0, 7))
				0: wval = 32'h7FFF_FFFF;
				1: wval = 32'h8000_0000;
				2: wval = '1;
				3: wval = '0;
				default: wval = $urandom;
			endcase
			access($urandom_range(0, 1) ? OP_PUT : OP_GET, key, wval);
		end
	endtask

	initial begin
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: miss on an empty cache, extreme keys and values, an update.
		access(OP_GET, 32'h0000_0000, 32'h0000_0000);
		access(OP_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
		access(OP_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
		access(OP_PUT, 32'h1234_5678, 32'hFFFF_FFFF);
		access(OP_PUT, 32'h5555_5555, 32'h0000_0000);
		access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		access(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		access(OP_PUT, 32'h1234_5678, 32'h0000_0001);
		access(OP_GET, 32'hAAAA_AAAA, 32'h0000_0000);
		access(OP_GET, 32'h1234_5678, 32'h0000_0000);

		// Capacity lowered below occupancy: old entries still hit until a new key goes in.
		set_capacity(5'd2);
		access(OP_GET, 32'h5555_5555, 32'h0000_0000);
		access(OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
		access(OP_GET, 32'h0000_0000, 32'h0000_0000);
		access(OP_GET, 32'hAAAA_AAAA, 32'h0000_0000);

		// A zero capacity holds a single entry.
		set_capacity(5'd0);
		access(OP_PUT, 32'h0000_0001, 32'hAAAA_AAAA);
		access(OP_PUT, 32'h0000_0002, 32'h1234_5678);
		access(OP_GET, 32'h0000_0001, 32'h0000_0000);
		access(OP_GET, 32'h0000_0002, 32'h0000_0000);

		// Capacity above the depth saturates.
		set_capacity(5'd31);
		access(OP_PUT, 32'h0000_0003, 32'h0F0F_0F0F);
		access(OP_GET, 32'h0000_0002, 32'h0000_0000);
		access(OP_PUT, 32'h0000_0002, 32'hF0F0_F0F0);
		access(OP_GET, 32'h0000_0003, 32'h0000_0000);

		foreach (phase_caps[p]) begin
			if (p == $size(phase_caps) - 1)
				calm <= 1'b1;
			run_phase(phase_caps[p], PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("lru_key_value_cache_core regression: pass");
		end else begin
			$display("lru_key_value_cache_core regression: fail");
		end
		$finish;
	end

endmodule

FILE: lru_key_value_cache_core.f
rtl/lkv_pkg.sv
rtl/lkv_ctrl.sv
rtl/lkv_dp.sv
rtl/lru_key_value_cache_core.sv
bench/lru_key_value_cache_checker.sv
bench/lru_key_value_cache_core_tb.sv
